### src/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared widths, register indexes and controller/datapath handshake types
// for the trapezoidal speed profile block.
// ----------------------------------------------------------------------------
package tsp_pkg;

    // fixed-point format of speed and distance
    localparam int FRAC_BITS = 8;
    localparam int DT_FRAC   = 16;

    localparam int DT_W    = 16;
    localparam int ACC_W   = 16;
    localparam int LEN_W   = 16;
    localparam int MAXV_W  = 12;
    localparam int SPEED_W = MAXV_W + FRAC_BITS;
    localparam int POS_W   = 17 + FRAC_BITS;
    localparam int ENDQ_W  = LEN_W + FRAC_BITS;
    localparam int REM_W   = ENDQ_W;

    // accel*dt product and the unclamped speed sum
    localparam int ADT_W = ACC_W + DT_W;
    localparam int V_W   = ADT_W - (DT_FRAC - FRAC_BITS) + 1;

    // radicand is (accel*rem) << (FRAC_BITS+1), padded to an even width
    localparam int PROD_W     = ACC_W + REM_W;
    localparam int ROOT_W     = 17 + FRAC_BITS;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);

    localparam int SD_W = SPEED_W + DT_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd2;

    localparam logic [ACC_W-1:0]  ACCEL_RST     = 16'd1500;
    localparam logic [LEN_W-1:0]  LENGTH_RST    = 16'd0;
    localparam logic [MAXV_W-1:0] MAX_SPEED_RST = 12'd1000;

    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_START   = 1'b1;

    typedef struct packed {
        logic load;
        logic clear;
        logic mul_acc;
        logic mul_rem;
        logic sqrt_start;
        logic cap;
        logic mul_step;
        logic move;
        logic out_load;
    } tsp_cmd_t;

    typedef struct packed {
        logic op_start;
        logic sqrt_done;
        logic out_free;
    } tsp_status_t;

endpackage

### src/tsp_if.sv
// ----------------------------------------------------------------------------
// tsp_if
// Valid/ready channels of the trapezoidal speed profile block: tick input,
// result output and configuration write.
// ----------------------------------------------------------------------------
interface tsp_tick_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [tsp_pkg::DT_W-1:0]   time_step;

    modport source (output valid, op, time_step, input ready);
    modport sink   (input valid, op, time_step, output ready);
endinterface

interface tsp_result_if;
    logic                         valid;
    logic                         ready;
    logic [tsp_pkg::SPEED_W-1:0]  speed_q8;
    logic [tsp_pkg::POS_W-1:0]    travelled_q8;
    logic [tsp_pkg::SPEED_W-1:0]  step_distance_q8;
    logic                         at_end;

    modport source (output valid, speed_q8, travelled_q8, step_distance_q8, at_end,
                    input ready);
    modport sink   (input valid, speed_q8, travelled_q8, step_distance_q8, at_end,
                    output ready);
endinterface

interface tsp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tsp_pkg::CFG_IDX_W-1:0]   index;
    logic [tsp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/tsp_sqrt.sv
// ----------------------------------------------------------------------------
// tsp_sqrt
// Restoring integer square root, one result bit per cycle, floor rounding.
// ----------------------------------------------------------------------------
module tsp_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tsp_pkg::RAD_W-1:0]   radicand,
    output logic                        done,
    output logic [tsp_pkg::ROOT_W-1:0]  root
);

    localparam int RW = tsp_pkg::ROOT_W;

    logic                               busy_reg;
    logic                               done_reg;
    logic [tsp_pkg::ROOT_CNT_W-1:0]     cnt_reg;
    logic [tsp_pkg::RAD_W-1:0]          rad_reg;
    logic [RW+1:0]                      rem_reg;
    logic [RW-1:0]                      root_reg;

    logic [RW+3:0]                      acc;
    logic [RW+3:0]                      sub;
    logic [RW+3:0]                      diff;

    // bring down the next two radicand bits and try root*4+1
    assign acc  = {1'b0, rem_reg[RW:0], rad_reg[tsp_pkg::RAD_W-1 -: 2]};
    assign sub  = {2'b00, root_reg, 2'b01};
    assign diff = acc - sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == tsp_pkg::ROOT_CNT_W'(RW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (!diff[RW+3])
            begin
                rem_reg  <= diff[RW+1:0];
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= acc[RW+1:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### src/tsp_datapath.sv
// ----------------------------------------------------------------------------
// tsp_datapath
// Configuration registers, speed and position state, the multiply steps,
// the square-root cap and the result register.
// ----------------------------------------------------------------------------
module tsp_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tsp_pkg::tsp_cmd_t                cmd,
    output tsp_pkg::tsp_status_t             status,
    input  logic                             tick_op,
    input  logic [tsp_pkg::DT_W-1:0]         tick_time_step,
    input  logic                             cfg_we,
    input  logic [tsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [tsp_pkg::SPEED_W-1:0]      result_speed_q8,
    output logic [tsp_pkg::POS_W-1:0]        result_travelled_q8,
    output logic [tsp_pkg::SPEED_W-1:0]      result_step_distance_q8,
    output logic                             result_at_end
);

    localparam int FB = tsp_pkg::FRAC_BITS;

    logic [tsp_pkg::ACC_W-1:0]    accel_reg;
    logic [tsp_pkg::LEN_W-1:0]    length_reg;
    logic [tsp_pkg::MAXV_W-1:0]   max_speed_reg;

    logic [tsp_pkg::SPEED_W-1:0]  speed_reg;
    logic [tsp_pkg::POS_W-1:0]    position_reg;
    logic                         out_valid_reg;

    logic                         op_reg;
    logic [tsp_pkg::DT_W-1:0]     dt_reg;
    logic [tsp_pkg::ADT_W-1:0]    adt_reg;
    logic                         gt_reg;
    logic [tsp_pkg::REM_W-1:0]    rem_reg;
    logic [tsp_pkg::RAD_W-1:0]    rad_reg;
    logic [tsp_pkg::V_W-1:0]      v_reg;
    logic [tsp_pkg::SPEED_W-1:0]  step_reg;

    logic [tsp_pkg::SPEED_W-1:0]  out_speed_reg;
    logic [tsp_pkg::POS_W-1:0]    out_pos_reg;
    logic [tsp_pkg::SPEED_W-1:0]  out_step_reg;
    logic                         out_end_reg;

    logic [tsp_pkg::ENDQ_W-1:0]   end_q;
    logic [tsp_pkg::PROD_W-1:0]   prod;
    logic [tsp_pkg::SD_W-1:0]     sd;
    logic                         sqrt_done;
    logic [tsp_pkg::ROOT_W-1:0]   root;
    logic [tsp_pkg::V_W-1:0]      vcap;
    logic [tsp_pkg::V_W-1:0]      ceiling;
    logic [tsp_pkg::V_W-1:0]      v_min;
    logic [tsp_pkg::V_W-1:0]      v_lim;
    logic [tsp_pkg::POS_W:0]      pos_sum;
    logic [tsp_pkg::POS_W-1:0]    pos_next;
    logic                         at_end;

    assign end_q   = {length_reg, {FB{1'b0}}};
    assign prod    = accel_reg * rem_reg;
    assign sd      = speed_reg * dt_reg;

    // cap order: square-root brake curve first, then the speed ceiling
    assign vcap    = gt_reg ? tsp_pkg::V_W'(root) : '0;
    assign ceiling = tsp_pkg::V_W'({max_speed_reg, {FB{1'b0}}});
    assign v_min   = (v_reg > vcap) ? vcap : v_reg;
    assign v_lim   = (v_min > ceiling) ? ceiling : v_min;

    assign pos_sum  = {1'b0, position_reg} + (tsp_pkg::POS_W + 1)'(step_reg);
    assign pos_next = pos_sum[tsp_pkg::POS_W] ? '1 : pos_sum[tsp_pkg::POS_W-1:0];
    assign at_end   = position_reg >= tsp_pkg::POS_W'(end_q);

    tsp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (rad_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg     <= tsp_pkg::ACCEL_RST;
            length_reg    <= tsp_pkg::LENGTH_RST;
            max_speed_reg <= tsp_pkg::MAX_SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsp_pkg::REG_ACCEL:     accel_reg     <= cfg_data;
                tsp_pkg::REG_LENGTH:    length_reg    <= cfg_data;
                tsp_pkg::REG_MAX_SPEED: max_speed_reg <= cfg_data[tsp_pkg::MAXV_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= '0;
            position_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                speed_reg    <= '0;
                position_reg <= '0;
            end
            else
            begin
                if (cmd.cap)
                    speed_reg <= v_lim[tsp_pkg::SPEED_W-1:0];
                if (cmd.move)
                    position_reg <= pos_next;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= tick_op;
            dt_reg <= tick_time_step;
        end
        if (cmd.mul_acc)
        begin
            adt_reg <= accel_reg * dt_reg;
            gt_reg  <= {1'b0, end_q} > position_reg;
            rem_reg <= tsp_pkg::REM_W'({1'b0, end_q} - position_reg);
        end
        if (cmd.mul_rem)
        begin
            rad_reg <= tsp_pkg::RAD_W'({prod, {(FB + 1){1'b0}}});
            v_reg   <= tsp_pkg::V_W'(speed_reg)
                     + tsp_pkg::V_W'(adt_reg >> (tsp_pkg::DT_FRAC - FB));
        end
        if (cmd.clear)
            step_reg <= '0;
        else if (cmd.mul_step)
            step_reg <= tsp_pkg::SPEED_W'(sd >> tsp_pkg::DT_FRAC);
        if (cmd.out_load)
        begin
            out_speed_reg <= speed_reg;
            out_pos_reg   <= position_reg;
            out_step_reg  <= step_reg;
            out_end_reg   <= at_end;
        end
    end

    assign status.op_start  = (op_reg == tsp_pkg::OP_START);
    assign status.sqrt_done = sqrt_done;
    assign status.out_free  = !out_valid_reg || result_ready;

    assign result_valid            = out_valid_reg;
    assign result_speed_q8         = out_speed_reg;
    assign result_travelled_q8     = out_pos_reg;
    assign result_step_distance_q8 = out_step_reg;
    assign result_at_end           = out_end_reg;

endmodule

### src/tsp_ctrl.sv
// ----------------------------------------------------------------------------
// tsp_ctrl
// Sequencer: steps one tick word through the multiply, square-root, cap and
// position-update phases of the datapath, or through the clear phase for a start tick.
// ----------------------------------------------------------------------------
module tsp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_ready,
    input  tsp_pkg::tsp_status_t  status,
    output tsp_pkg::tsp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_MUL_ACC,
        S_MUL_REM,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_CAP,
        S_MUL_STEP,
        S_MOVE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        tick_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                tick_ready = 1'b1;
                cmd.load   = tick_valid;
                if (tick_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
                state_next = status.op_start ? S_CLEAR : S_MUL_ACC;
            S_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = S_DONE;
            end
            S_MUL_ACC:
            begin
                cmd.mul_acc = 1'b1;
                state_next  = S_MUL_REM;
            end
            S_MUL_REM:
            begin
                cmd.mul_rem = 1'b1;
                state_next  = S_SQRT_GO;
            end
            S_SQRT_GO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
                if (status.sqrt_done)
                    state_next = S_CAP;
            S_CAP:
            begin
                cmd.cap    = 1'b1;
                state_next = S_MUL_STEP;
            end
            S_MUL_STEP:
            begin
                cmd.mul_step = 1'b1;
                state_next   = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold here while the previous result word is still unclaimed
                cmd.out_load = status.out_free;
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### src/trapezoid_speed_profile_top.sv
// ----------------------------------------------------------------------------
// trapezoid_speed_profile_top
// Trapezoidal speed profile generator: speed and travelled distance updated
// per time-step tick, with an acceleration limit, a square-root braking cap
// and a speed ceiling.
// ----------------------------------------------------------------------------
//  channel  | role    | word
//  ---------+---------+---------------------------------------------------
//  tick     | sink    | op, time_step
//  result   | source  | speed_q8, travelled_q8, step_distance_q8, at_end
//  cfg      | sink    | index, data (acceleration, path_length, max_speed)
//
//  an advance tick runs dispatch, two multiply phases, the 25-step bit-serial
//  square root, cap, step multiply and move; a start tick runs dispatch and clear
//  one tick is in flight at a time; the next tick is taken once the result
//  has moved into the output register, even if that word is not yet taken
//  a stalled result holds the sequencer in its last phase
//  async active-low reset loads the register defaults and clears speed/position
//  cfg is always ready
// ----------------------------------------------------------------------------
module trapezoid_speed_profile_top (
    input  logic          clk,
    input  logic          rst_n,
    tsp_tick_if.sink      tick,
    tsp_result_if.source  result,
    tsp_cfg_if.sink       cfg
);

    tsp_pkg::tsp_cmd_t     cmd;
    tsp_pkg::tsp_status_t  status;

    assign cfg.ready = 1'b1;

    tsp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick.valid),
        .tick_ready (tick.ready),
        .status     (status),
        .cmd        (cmd)
    );

    tsp_datapath u_datapath (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cmd                     (cmd),
        .status                  (status),
        .tick_op                 (tick.op),
        .tick_time_step          (tick.time_step),
        .cfg_we                  (cfg.valid),
        .cfg_index               (cfg.index),
        .cfg_data                (cfg.data),
        .result_valid            (result.valid),
        .result_ready            (result.ready),
        .result_speed_q8         (result.speed_q8),
        .result_travelled_q8     (result.travelled_q8),
        .result_step_distance_q8 (result.step_distance_q8),
        .result_at_end           (result.at_end)
    );

endmodule

### src/tsp_checker.sv
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks of the trapezoidal speed profile block, bound to the top.
// ----------------------------------------------------------------------------
module tsp_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick_valid,
    input  logic                         tick_ready,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  logic [tsp_pkg::SPEED_W-1:0]  result_speed_q8,
    input  logic [tsp_pkg::POS_W-1:0]    result_travelled_q8,
    input  logic [tsp_pkg::SPEED_W-1:0]  result_step_distance_q8,
    input  logic                         result_at_end
);

    localparam logic [tsp_pkg::SPEED_W-1:0] SPEED_CEIL =
        {{tsp_pkg::MAXV_W{1'b1}}, {tsp_pkg::FRAC_BITS{1'b0}}};

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
            && $stable(result_speed_q8) && $stable(result_travelled_q8)
            && $stable(result_step_distance_q8) && $stable(result_at_end))
        else $error("result word changed while stalled");

    // one tick in flight: no second word right after an accepted one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("tick taken while previous one is in flight");

    // a step never covers more than one second of travel at the new speed
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_step_distance_q8 <= result_speed_q8)
        else $error("step distance exceeds speed");

    // speed stays under the largest possible ceiling
    a_speed_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_speed_q8 <= SPEED_CEIL)
        else $error("speed above ceiling");

endmodule

bind trapezoid_speed_profile_top tsp_checker u_tsp_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .tick_valid              (tick.valid),
    .tick_ready              (tick.ready),
    .result_valid            (result.valid),
    .result_ready            (result.ready),
    .result_speed_q8         (result.speed_q8),
    .result_travelled_q8     (result.travelled_q8),
    .result_step_distance_q8 (result.step_distance_q8),
    .result_at_end           (result.at_end)
);
